/* design/sprite_to_x86_code_encoder_assert.svh */
// Assertion macros shared by the encoder's modules.
// Define ASSERT_OFF to compile them away.
`ifndef SPRITE_TO_X86_CODE_ENCODER_ASSERT_SVH
`define SPRITE_TO_X86_CODE_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SPX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SPX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/spx86_pkg.sv */
`timescale 1ns / 1ps
package spx86_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int LENGTH_BITS_DEF = 18;

  // Bound on the bytes one pixel can cause. The real worst case is 9: a disp16
  // word store plus the trailer, or header, byte store and trailer.
  localparam int MAX_RESULTS = 11;
  localparam int BURST_BITS  = 8 * MAX_RESULTS;
  localparam int CNT_W       = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH  = 3'd3;

  // 8086 opcodes and ModRM bytes
  localparam logic [7:0] OP_XCHG_AX_BX = 8'h93;
  localparam logic [7:0] OP_MOV_SREG   = 8'h8E;
  localparam logic [7:0] MODRM_DS_DX   = 8'hDA;
  localparam logic [7:0] OP_RETF       = 8'hCB;
  localparam logic [7:0] TRAILER_PAD   = 8'h00;
  localparam logic [7:0] OP_MOV_B      = 8'hC6;
  localparam logic [7:0] OP_MOV_W      = 8'hC7;
  localparam logic [7:0] MODRM_BX      = 8'h07;
  localparam logic [7:0] MODRM_BX_D8   = 8'h47;
  localparam logic [7:0] MODRM_BX_D16  = 8'h87;
  localparam logic [15:0] DISP8_MAX    = 16'd127;

  typedef struct packed {
    logic [7:0]            transparent_color;
    logic [CFG_DATA_W-1:0] sprite_width;
    logic [CFG_DATA_W-1:0] sprite_height;
    logic [CFG_DATA_W-1:0] target_width;
  } cfg_t;

  typedef struct packed {
    logic [47:0] bytes;
    logic [2:0]  len;
  } store_t;

  typedef struct packed {
    logic [BURST_BITS-1:0] bytes;
    logic [CNT_W-1:0]      count;
    logic                  done;
  } burst_t;

  // One MOV [BX+disp], imm store; first byte in bits 7:0.
  function automatic store_t enc_store(input logic word, input logic [15:0] off,
                                       input logic [15:0] data);
    store_t     s;
    logic [7:0] op;
    op      = word ? OP_MOV_W : OP_MOV_B;
    s.bytes = '0;
    if (off == 16'd0) begin
      s.bytes[31:0] = {data[15:8], data[7:0], MODRM_BX, op};
      s.len         = word ? 3'd4 : 3'd3;
    end else if (off <= DISP8_MAX) begin
      s.bytes[39:0] = {data[15:8], data[7:0], off[7:0], MODRM_BX_D8, op};
      s.len         = word ? 3'd5 : 3'd4;
    end else begin
      s.bytes       = {data[15:8], data[7:0], off[15:8], off[7:0], MODRM_BX_D16, op};
      s.len         = word ? 3'd6 : 3'd5;
    end
    if (!word) begin
      s.bytes[47:40] = 8'h00;
      if (off == 16'd0) s.bytes[31:24] = 8'h00;
      else if (off <= DISP8_MAX) s.bytes[39:32] = 8'h00;
    end
    return s;
  endfunction

endpackage

/* design/spx86_cfg.sv */
`timescale 1ns / 1ps
module spx86_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [spx86_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [spx86_pkg::CFG_DATA_W-1:0]      wr_data,
  output spx86_pkg::cfg_t                       cfg
);

  spx86_pkg::cfg_t cfg_r;
  spx86_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        spx86_pkg::CFG_TRANSPARENT:   cfg_nxt.transparent_color = wr_data[7:0];
        spx86_pkg::CFG_SPRITE_WIDTH:  cfg_nxt.sprite_width      = wr_data;
        spx86_pkg::CFG_SPRITE_HEIGHT: cfg_nxt.sprite_height     = wr_data;
        spx86_pkg::CFG_TARGET_WIDTH:  cfg_nxt.target_width      = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transparent_color <= 8'd0;
      cfg_r.sprite_width      <= 10'd16;
      cfg_r.sprite_height     <= 10'd16;
      cfg_r.target_width      <= 10'd320;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/spx86_encode.sv */
`timescale 1ns / 1ps
module spx86_encode #(
  parameter int COORD_BITS  = spx86_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS = spx86_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             pixel_value,
  input  spx86_pkg::cfg_t        cfg,
  output spx86_pkg::burst_t      burst,
  output logic [LENGTH_BITS-1:0] total
);

  localparam int CNT_W_L = spx86_pkg::CNT_W;

  logic [COORD_BITS-1:0]  col_r, col_nxt;
  logic [COORD_BITS-1:0]  row_r, row_nxt;
  logic [15:0]            row_base_r, row_base_nxt;
  logic                   pend_r, pend_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [LENGTH_BITS-1:0] byte_total_r, byte_total_nxt;

  logic [COORD_BITS-1:0]  last_col, last_row;
  logic                   opaque, row_end, img_end, first;
  logic                   has_store, store_word;
  logic [15:0]            store_off, store_data;
  spx86_pkg::store_t      st;
  logic [2:0]             slen;
  logic [CNT_W_L-1:0]     hlen, tpos, count;
  logic [23:0]            hdr, trl;

  // A size of zero wraps to the full coordinate range.
  assign last_col = COORD_BITS'(cfg.sprite_width) - COORD_BITS'(1);
  assign last_row = COORD_BITS'(cfg.sprite_height) - COORD_BITS'(1);
  assign opaque   = pixel_value != cfg.transparent_color;
  assign row_end  = col_r >= last_col;
  assign img_end  = row_end && (row_r >= last_row);
  assign first    = (col_r == '0) && (row_r == '0);

  always_comb begin
    has_store  = 1'b0;
    store_word = 1'b0;
    store_off  = row_base_r + 16'(col_r) - 16'd1;
    store_data = {8'h00, held_r};
    if (pend_r) begin
      // a waiting pixel is closed by whatever comes next
      has_store = 1'b1;
      if (opaque) begin
        store_word = 1'b1;
        store_data = {pixel_value, held_r};
      end
    end else if (opaque && row_end) begin
      // lone pixel at the end of a row
      has_store  = 1'b1;
      store_off  = row_base_r + 16'(col_r);
      store_data = {8'h00, pixel_value};
    end
  end

  assign st   = spx86_pkg::enc_store(store_word, store_off, store_data);
  assign slen = has_store ? st.len : 3'd0;
  assign hdr  = {spx86_pkg::MODRM_DS_DX, spx86_pkg::OP_MOV_SREG, spx86_pkg::OP_XCHG_AX_BX};
  assign trl  = {spx86_pkg::TRAILER_PAD, spx86_pkg::OP_RETF, spx86_pkg::OP_XCHG_AX_BX};
  assign hlen = first ? CNT_W_L'(3) : CNT_W_L'(0);
  assign tpos = hlen + CNT_W_L'(slen);
  assign count = tpos + (img_end ? CNT_W_L'(3) : CNT_W_L'(0));

  always_comb begin
    burst.bytes = '0;
    if (first) burst.bytes = spx86_pkg::BURST_BITS'(hdr);
    if (has_store) begin
      burst.bytes = burst.bytes | (spx86_pkg::BURST_BITS'(st.bytes) << {hlen, 3'b000});
    end
    if (img_end) begin
      burst.bytes = burst.bytes | (spx86_pkg::BURST_BITS'(trl) << {tpos, 3'b000});
    end
    burst.count = count;
    burst.done  = img_end;
  end

  assign total = byte_total_r + LENGTH_BITS'(count);

  always_comb begin
    pend_nxt       = opaque && !pend_r && !row_end;
    held_nxt       = pixel_value;
    col_nxt        = row_end ? '0 : col_r + COORD_BITS'(1);
    row_nxt        = row_r;
    row_base_nxt   = row_base_r;
    byte_total_nxt = total;
    if (img_end) begin
      row_nxt        = '0;
      row_base_nxt   = '0;
      byte_total_nxt = '0;
      held_nxt       = 8'd0;
    end else if (row_end) begin
      row_nxt      = row_r + COORD_BITS'(1);
      row_base_nxt = row_base_r + 16'(cfg.target_width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      row_base_r   <= '0;
      pend_r       <= 1'b0;
      held_r       <= 8'd0;
      byte_total_r <= '0;
    end else if (accept) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      row_base_r   <= row_base_nxt;
      pend_r       <= pend_nxt;
      held_r       <= held_nxt;
      byte_total_r <= byte_total_nxt;
    end
  end

endmodule

/* design/spx86_burst.sv */
`timescale 1ns / 1ps
`include "sprite_to_x86_code_encoder_assert.svh"
module spx86_burst #(
  parameter int LENGTH_BITS = spx86_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  spx86_pkg::burst_t      burst,
  input  logic [LENGTH_BITS-1:0] total,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_code_byte,
  output logic                   out_last_of_run,
  output logic                   out_image_done,
  output logic [LENGTH_BITS-1:0] out_code_length
);

  localparam int CW = spx86_pkg::CNT_W;

  logic [spx86_pkg::BURST_BITS-1:0] buf_r;
  logic [CW-1:0]                    rem_r;
  logic                             done_r;
  logic [LENGTH_BITS-1:0]           len_r;
  logic                             take, last_take, in_acc, load;

  assign out_valid = rem_r != '0;
  assign take      = out_valid && !out_stall;
  assign last_take = take && (rem_r == CW'(1));
  // the next pixel may enter while the final byte of this one leaves
  assign in_stall  = out_valid && !last_take;
  assign in_acc    = in_valid && !in_stall;
  assign load      = in_acc && (burst.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= burst.count;
    end else if (take) begin
      rem_r <= rem_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r  <= burst.bytes;
      done_r <= burst.done;
      len_r  <= total;
    end else if (take) begin
      buf_r <= buf_r >> 8;
    end
  end

  assign out_code_byte   = buf_r[7:0];
  assign out_last_of_run = rem_r == CW'(1);
  assign out_image_done  = out_last_of_run && done_r;
  assign out_code_length = out_image_done ? len_r : '0;

  `SPX_ASSERT_IMPL(a_rem_bound, clk, rst_n, 1'b1, rem_r <= CW'(spx86_pkg::MAX_RESULTS))
  `SPX_ASSERT_IMPL(a_acc_only_on_last, clk, rst_n, in_acc && out_valid, last_take)
  `SPX_ASSERT_NEXT(a_rem_counts_down, clk, rst_n, take && rem_r > CW'(1), rem_r == $past(rem_r) - CW'(1))

endmodule

/* design/sprite_to_x86_code_encoder.sv */
`timescale 1ns / 1ps
// Channel | Handshake           | Payload
// in_     | in_valid / in_stall | in_pixel_value[7:0]
// out_    | out_valid/out_stall | out_code_byte, out_last_of_run, out_image_done,
//         |                     | out_code_length
// cfg_    | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[9:0]
//
// A pixel is encoded in one pass as it is accepted; its bytes (0 to 9, at most 9
// for a disp16 word store plus trailer) leave through a byte-wide shift buffer,
// one per cycle while out_stall is low.
// The next pixel is taken in the cycle the previous burst's last byte leaves.
// rst_n (synchronous, active low) restores register defaults, starts a fresh image.
// out_stall freezes the current byte and backs up into in_stall; cfg_ready is always high.
module sprite_to_x86_code_encoder #(
  parameter int COORD_BITS  = spx86_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS = spx86_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_code_byte,
  output logic                              out_last_of_run,
  output logic                              out_image_done,
  output logic [LENGTH_BITS-1:0]            out_code_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spx86_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spx86_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spx86_pkg::cfg_t        cfg;
  spx86_pkg::burst_t      burst;
  logic [LENGTH_BITS-1:0] total;
  logic                   in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // configuration registers; a write applies to the next pixel encoded
  spx86_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // raster position, pairing state and the per-pixel byte burst
  spx86_encode #(
    .COORD_BITS  (COORD_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_encode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .pixel_value (in_pixel_value),
    .cfg         (cfg),
    .burst       (burst),
    .total       (total)
  );

  // holds one burst and plays it out a byte at a time
  spx86_burst #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_burst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .burst           (burst),
    .total           (total),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_byte   (out_code_byte),
    .out_last_of_run (out_last_of_run),
    .out_image_done  (out_image_done),
    .out_code_length (out_code_length)
  );

endmodule

/* bench/sprite_to_x86_code_encoder_tb.sv */
`timescale 1ns / 1ps
module sprite_to_x86_code_encoder_tb;

  localparam int LW         = spx86_pkg::LENGTH_BITS_DEF;
  localparam int IW         = spx86_pkg::CFG_INDEX_W;
  localparam int DW         = spx86_pkg::CFG_DATA_W;
  localparam int QUIET_MAX  = 2000;  // cycles with no handshake at all before giving up
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, fills the block
  localparam logic [IW-1:0] CFG_UNUSED = 3'd7;

  // One code byte as the block should emit it
  typedef struct packed {
    logic [7:0]    code;
    logic          last;
    logic          done;
    logic [LW-1:0] total;
  } code_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_pixel_value = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_code_byte;
  logic                   out_last_of_run;
  logic                   out_image_done;
  logic [LW-1:0]          out_code_length;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IW-1:0]          cfg_index = '0;
  logic [DW-1:0]          cfg_data = '0;

  sprite_to_x86_code_encoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_byte   (out_code_byte),
    .out_last_of_run (out_last_of_run),
    .out_image_done  (out_image_done),
    .out_code_length (out_code_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Pixels waiting to be offered, and code bytes still owed by the block
  logic [7:0] pixel_queue[$];
  code_item_t code_due[$];

  int  mismatches = 0;
  bit  idle_on = 1'b1;   // random gaps on both sides
  int  hold_ask = 0;     // bumped to request one long receiver hold-off
  int  hold_grant = 0;

  // Register copies, reset values
  logic [7:0]  reg_transp = 8'd0;
  logic [9:0]  reg_width  = 10'd16;
  logic [9:0]  reg_height = 10'd16;
  logic [9:0]  reg_stride = 10'd320;

  // Encoder state copy
  logic [9:0]    enc_col = '0;
  logic [9:0]    enc_row = '0;
  logic [15:0]   enc_base = '0;
  logic          enc_pending = 1'b0;
  logic [7:0]    enc_held = '0;
  logic [LW-1:0] enc_total = '0;

  function automatic void push_byte(input logic [7:0] b);
    code_item_t e;
    e.code  = b;
    e.last  = 1'b0;
    e.done  = 1'b0;
    e.total = '0;
    code_due.push_back(e);
    enc_total = enc_total + 1'b1;
  endfunction

  // MOV [BX+disp], imm8/imm16 -- shortest displacement form for the offset
  function automatic void push_store(input logic word, input logic [15:0] off,
                                     input logic [15:0] data);
    push_byte(word ? spx86_pkg::OP_MOV_W : spx86_pkg::OP_MOV_B);
    if (off == 16'd0) begin
      push_byte(spx86_pkg::MODRM_BX);
    end else if (off <= spx86_pkg::DISP8_MAX) begin
      push_byte(spx86_pkg::MODRM_BX_D8);
      push_byte(off[7:0]);
    end else begin
      push_byte(spx86_pkg::MODRM_BX_D16);
      push_byte(off[7:0]);
      push_byte(off[15:8]);
    end
    push_byte(data[7:0]);
    if (word) push_byte(data[15:8]);
  endfunction

  // Expected code bytes for one accepted pixel
  function automatic void encode_pixel(input logic [7:0] pix);
    int         first;
    logic [9:0] col;
    logic [9:0] last_col;
    logic [9:0] last_row;
    code_item_t e;
    first    = code_due.size();
    col      = enc_col;
    last_col = reg_width - 10'd1;   // size 0 wraps to 1023, i.e. 1024 pixels
    last_row = reg_height - 10'd1;

    if (col == 10'd0 && enc_row == 10'd0) begin
      push_byte(spx86_pkg::OP_XCHG_AX_BX);
      push_byte(spx86_pkg::OP_MOV_SREG);
      push_byte(spx86_pkg::MODRM_DS_DX);
    end

    // Pair opaque pixels; a lone one closed by a transparent pixel is a byte store
    if (pix != reg_transp) begin
      if (enc_pending) begin
        push_store(1'b1, enc_base + col - 16'd1, {pix, enc_held});
        enc_pending = 1'b0;
      end else begin
        enc_pending = 1'b1;
      end
    end else if (enc_pending) begin
      push_store(1'b0, enc_base + col - 16'd1, {8'h00, enc_held});
      enc_pending = 1'b0;
    end
    enc_held = pix;

    // Row end (also when the width was lowered below the current column)
    if (col >= last_col) begin
      if (enc_pending) begin
        push_store(1'b0, enc_base + col, {8'h00, enc_held});
        enc_pending = 1'b0;
      end
      enc_col = '0;
      if (enc_row >= last_row) begin
        push_byte(spx86_pkg::OP_XCHG_AX_BX);
        push_byte(spx86_pkg::OP_RETF);
        push_byte(spx86_pkg::TRAILER_PAD);
        e = code_due.pop_back();
        e.done  = 1'b1;
        e.total = enc_total;   // wraps at 2^LW
        code_due.push_back(e);
        enc_row   = '0;
        enc_base  = '0;
        enc_total = '0;
        enc_held  = '0;
      end else begin
        enc_row  = enc_row + 10'd1;
        enc_base = enc_base + {6'd0, reg_stride};
      end
    end else begin
      enc_col = col + 10'd1;
    end

    if (code_due.size() > first) begin
      e = code_due.pop_back();
      e.last = 1'b1;
      code_due.push_back(e);
    end
  endfunction

  // Driver: offers queued pixels, random gap bursts between items
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        encode_pixel(in_pixel_value);
        void'(pixel_queue.pop_front());
      end
      // a stalled item stays put; otherwise pick the next thing to drive
      if (!in_valid || !in_stall) begin
        if (idle_on && gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          gap_left = $urandom_range(0, 4);
        end else if (pixel_queue.size() > 0) begin
          in_valid       <= 1'b1;
          in_pixel_value <= pixel_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted byte, drives out_stall
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    code_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (code_due.size() == 0) begin
          $error("code_byte: expected none, got %02h", out_code_byte);
          mismatches++;
        end else begin
          e = code_due.pop_front();
          if (out_code_byte !== e.code) begin
            $error("code_byte: expected %02h, got %02h", e.code, out_code_byte);
            mismatches++;
          end
          if (out_last_of_run !== e.last) begin
            $error("last_of_run: expected %0d, got %0d", e.last, out_last_of_run);
            mismatches++;
          end
          if (out_image_done !== e.done) begin
            $error("image_done: expected %0d, got %0d", e.done, out_image_done);
            mismatches++;
          end
          if (out_code_length !== e.total) begin
            $error("code_length: expected %0d, got %0d", e.total, out_code_length);
            mismatches++;
          end
        end
      end

      if (hold_grant != hold_ask) begin
        hold_grant = hold_ask;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: no handshake on any channel for too long
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("** sprite_to_x86_code_encoder: FAILED **");
      $finish;
    end
  end

  // Register write; mirrors the new value once the write lands
  task automatic write_reg(input logic [IW-1:0] idx,
                           input logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      spx86_pkg::CFG_TRANSPARENT:   reg_transp = val[7:0];
      spx86_pkg::CFG_SPRITE_WIDTH:  reg_width  = val;
      spx86_pkg::CFG_SPRITE_HEIGHT: reg_height = val;
      spx86_pkg::CFG_TARGET_WIDTH:  reg_stride = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [9:0] transp, input logic [9:0] w,
                              input logic [9:0] h, input logic [9:0] stride);
    write_reg(spx86_pkg::CFG_TRANSPARENT, transp);
    write_reg(spx86_pkg::CFG_SPRITE_WIDTH, w);
    write_reg(spx86_pkg::CFG_SPRITE_HEIGHT, h);
    write_reg(spx86_pkg::CFG_TARGET_WIDTH, stride);
  endtask

  // Wait until every pixel is taken and every byte has come out, then let a
  // pixel that emits nothing finish inside the block.
  task automatic settle();
    while (pixel_queue.size() != 0 || code_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_list(input logic [7:0] list[$]);
    foreach (list[i]) pixel_queue.push_back(list[i]);
  endtask

  // Random sizes mostly small, with the extremes mixed in; about a third of
  // the pixels transparent so byte stores and pairs both show up.
  task automatic random_phase(input int count);
    logic [9:0] w;
    logic [9:0] h;
    logic [9:0] stride;
    case ($urandom_range(0, 7))
      0:       w = 10'd1;
      1:       w = 10'd1023;
      default: w = 10'($urandom_range(2, 6));
    endcase
    case ($urandom_range(0, 5))
      0:       h = 10'd1;
      1:       h = 10'd1023;
      default: h = 10'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 3))
      0:       stride = 10'd1;
      1:       stride = 10'd1023;
      default: stride = 10'($urandom_range(1, 1023));
    endcase
    program_regs(10'($urandom_range(0, 1023)), w, h, stride);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0)
        pixel_queue.push_back(reg_transp);
      else
        pixel_queue.push_back(8'($urandom_range(0, 255)));
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pairs, lone pixels closed by transparent and by row end, 00/FF data,
    // no-displacement and disp8 forms.
    program_regs(10'h000, 10'd5, 10'd2, 10'd100);
    queue_list('{8'hFF, 8'h01, 8'h80, 8'h00, 8'hAA, 8'h00, 8'h7F, 8'h80, 8'h00, 8'h00});
    settle();

    // Offsets 127 and 129 around the disp8 limit, 0xFF as transparent
    program_regs(10'h0FF, 10'd3, 10'd3, 10'd127);
    queue_list('{8'h00, 8'h00, 8'h00, 8'h12, 8'hFF, 8'h34, 8'h56, 8'h78, 8'hFF});
    settle();

    // Width lowered mid-row: the next pixel closes the row and the image.
    // The write to an unused index must change nothing.
    program_regs(10'h300, 10'd8, 10'd1, 10'd1023);
    queue_list('{8'h11, 8'h22, 8'h33, 8'h00});
    settle();
    write_reg(CFG_UNUSED, 10'h3FF);
    write_reg(spx86_pkg::CFG_SPRITE_WIDTH, 10'd2);
    queue_list('{8'h44});
    settle();

    random_phase(30);
    random_phase(30);
    hold_ask++;   // receiver holds off while pixels keep coming
    random_phase(30);
    random_phase(30);
    random_phase(30);
    idle_on = 1'b0;
    random_phase(20);

    // Close whatever image is open so the next one starts fresh
    program_regs(10'h000, 10'd1, 10'd1, 10'd1);
    queue_list('{8'h5A});
    settle();

    // One pixel per row, 70 rows at the widest stride: row_base wraps past
    // 65535 inside the image.
    program_regs(10'h000, 10'd1, 10'd70, 10'd1023);
    repeat (70) pixel_queue.push_back(8'($urandom_range(1, 255)));
    settle();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && code_due.size() == 0)
      $display("** sprite_to_x86_code_encoder: PASSED **");
    else
      $display("** sprite_to_x86_code_encoder: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/spx86_pkg.sv
design/spx86_cfg.sv
design/spx86_encode.sv
design/spx86_burst.sv
design/sprite_to_x86_code_encoder.sv
bench/sprite_to_x86_code_encoder_tb.sv
